// ----- design/sm3_pkg.sv -----
// ----------------------------------------------------------------------------
// SM3 package
// Shared constants, types and round helper functions for the SM3 engine.
// ----------------------------------------------------------------------------
package sm3_pkg;

  localparam logic [31:0] IV0 = 32'h7380166f;
  localparam logic [31:0] IV1 = 32'h4914b2b9;
  localparam logic [31:0] IV2 = 32'h172442d7;
  localparam logic [31:0] IV3 = 32'hda8a0600;
  localparam logic [31:0] IV4 = 32'ha96f30bc;
  localparam logic [31:0] IV5 = 32'h163138aa;
  localparam logic [31:0] IV6 = 32'he38dee4d;
  localparam logic [31:0] IV7 = 32'hb0fb0e4e;
  localparam logic [31:0] TJ_LO = 32'h79cc4519;
  localparam logic [31:0] TJ_HI = 32'h7a879d8a;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [5:0]  LEN_POS = 6'd56;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMP,
    ST_PAD,
    ST_LEN,
    ST_OUT
  } state_e;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic logic [31:0] perm0(input logic [31:0] x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic logic [31:0] perm1(input logic [31:0] x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

endpackage

// ----- design/sm3_round.sv -----
// ----------------------------------------------------------------------------
// SM3 round unit
// One compression round and one message-expansion step per cycle, shared
// over all 64 rounds of a block.
// ----------------------------------------------------------------------------
module sm3_round import sm3_pkg::*; (
  input  logic [5:0]       rnd_i,
  input  logic [31:0]      v_i [8],
  input  logic [31:0]      w_i [16],
  output logic [31:0]      v_o [8],
  output logic [31:0]      wnew_o
);

  logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, tj, wj, wpj;

  always_comb begin
    // window holds w[j..j+15]; new word is w[j+16]
    wnew_o = perm1(w_i[0] ^ w_i[7] ^ rotl(w_i[13], 5'd15)) ^ rotl(w_i[3], 5'd7) ^ w_i[10];
    wj  = w_i[0];
    wpj = w_i[0] ^ w_i[4];
    tj  = rnd_i[5:4] == 2'd0 ? TJ_LO : TJ_HI;
    a12 = rotl(v_i[0], 5'd12);
    ss1 = rotl(a12 + v_i[4] + rotl(tj, rnd_i[4:0]), 5'd7);
    ss2 = ss1 ^ a12;
    if (rnd_i[5:4] == 2'd0) begin
      ff = v_i[0] ^ v_i[1] ^ v_i[2];
      gg = v_i[4] ^ v_i[5] ^ v_i[6];
    end else begin
      ff = (v_i[0] & v_i[1]) | (v_i[0] & v_i[2]) | (v_i[1] & v_i[2]);
      gg = (v_i[4] & v_i[5]) | (~v_i[4] & v_i[6]);
    end
    tt1 = ff + v_i[3] + ss2 + wpj;
    tt2 = gg + v_i[7] + ss1 + wj;
    v_o[0] = tt1;
    v_o[1] = v_i[0];
    v_o[2] = rotl(v_i[1], 5'd9);
    v_o[3] = v_i[2];
    v_o[4] = perm0(tt2);
    v_o[5] = v_i[4];
    v_o[6] = rotl(v_i[5], 5'd19);
    v_o[7] = v_i[6];
  end

endmodule

// ----- design/sm3_hash_engine.sv -----
// ----------------------------------------------------------------------------
// SM3 hash engine
// Byte-serial SM3 hash with padding and a 256-bit digest as eight words.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  in      | in_valid_i/in_ready_o, data_byte_i, ...   | request in
//  out     | out_valid_o/out_ready_i, digest_word_o ...| eight words out
//
// A byte that does not fill the block is written into the buffer. A
// byte filling the block is accepted, then runs 64 rounds at one per cycle
// through the shared round unit, then the chaining update. A finish takes up
// to two compressions, padding byte by byte up to the end of each block, and
// then sends eight output words that wait on out_ready_i. Reset restores the
// initial value; the buffer is not cleared.
module sm3_hash_engine import sm3_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        has_byte_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  state_e      state_q, state_d;
  logic [31:0] cv_q [8];
  logic [31:0] v_q [8];
  logic [31:0] w_q [16];
  logic [31:0] v_nx [8];
  logic [31:0] wnew;
  logic [5:0]  fill_q;
  logic [63:0] len_q;
  logic [6:0]  rnd_q;
  logic        fin_q;    // compression belongs to a finish
  logic        final_q;  // this compression is the last of the message
  logic [2:0]  oidx_q;
  logic        acc;
  logic        pad_done_q; // 0x80 already written in this finish

  assign acc = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign digest_word_o = cv_q[oidx_q];
  assign word_index_o = oidx_q;
  assign last_word_o = (oidx_q == 3'd7);

  sm3_round u_round (
    .rnd_i (rnd_q[5:0]),
    .v_i   (v_q),
    .w_i   (w_q),
    .v_o   (v_nx),
    .wnew_o(wnew)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // byte written into the word window this cycle
  logic       wr_en;
  logic [7:0] wr_byte;
  logic       start_comp;

  always_comb begin
    state_d = state_q;
    wr_en = 1'b0;
    wr_byte = data_byte_i;
    start_comp = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          if (has_byte_i) begin
            wr_en = 1'b1;
            if (fill_q == 6'd63) begin
              start_comp = 1'b1;
              state_d = ST_COMP;
            end else if (end_of_message_i) begin
              state_d = ST_PAD;
            end
          end else if (end_of_message_i) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_COMP: begin
        if (rnd_q == 7'd64) begin
          if (final_q) state_d = ST_OUT;
          else if (fin_q) state_d = ST_PAD;
          else state_d = ST_IDLE;
        end
      end
      ST_PAD: begin
        // first pad step writes 0x80, later ones zero the block
        wr_en = 1'b1;
        wr_byte = pad_done_q ? 8'h00 : PAD_BYTE;
        if (fill_q == 6'd63) begin
          start_comp = 1'b1;
          state_d = ST_COMP;
        end else if (fill_q == 6'd55) begin
          state_d = ST_LEN;
        end else begin
          state_d = ST_LEN;
        end
        if (fill_q > 6'd55 && fill_q != 6'd63) state_d = ST_PAD;
      end
      ST_LEN: begin
        wr_en = 1'b1;
        if (fill_q < LEN_POS) wr_byte = 8'h00;
        else wr_byte = len_q[8'd63 - {fill_q[2:0], 3'b000} -: 8];
        if (fill_q == 6'd63) begin
          start_comp = 1'b1;
          state_d = ST_COMP;
        end
      end
      ST_OUT: begin
        if (out_ready_i && oidx_q == 3'd7) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q <= '{IV0, IV1, IV2, IV3, IV4, IV5, IV6, IV7};
      fill_q <= '0;
      len_q <= '0;
      rnd_q <= '0;
      fin_q <= 1'b0;
      final_q <= 1'b0;
      oidx_q <= '0;
      pad_done_q <= 1'b0;
    end else begin
      if (acc) begin
        fin_q <= end_of_message_i;
        final_q <= 1'b0;
        pad_done_q <= 1'b0;
        if (has_byte_i) len_q <= len_q + 64'd8;
      end
      if (wr_en) fill_q <= fill_q + 6'd1;
      if (state_q == ST_PAD && !pad_done_q) pad_done_q <= 1'b1;
      if (state_q == ST_LEN && fill_q == 6'd63) final_q <= 1'b1;
      if (start_comp) rnd_q <= '0;
      if (state_q == ST_COMP) begin
        rnd_q <= rnd_q + 7'd1;
        if (rnd_q == 7'd64) begin
          for (int k = 0; k < 8; k++) cv_q[k] <= cv_q[k] ^ v_q[k];
        end
      end
      if (state_q == ST_OUT && out_ready_i) begin
        oidx_q <= oidx_q + 3'd1;
        if (oidx_q == 3'd7) begin
          cv_q <= '{IV0, IV1, IV2, IV3, IV4, IV5, IV6, IV7};
          len_q <= '0;
          fill_q <= '0;
        end
      end
    end
  end

  // Working variables and message window: payload, no reset.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      w_q[fill_q[5:2]][8'd31 - {fill_q[1:0], 3'b000} -: 8] <= wr_byte;
    end
    if (start_comp) begin
      v_q <= cv_q;
    end
    if (state_q == ST_COMP && rnd_q < 7'd64) begin
      v_q <= v_nx;
      for (int k = 0; k < 15; k++) w_q[k] <= w_q[k + 1];
      w_q[15] <= wnew;
    end
  end

endmodule

// ----- tb/sm3_hash_checker.sv -----
// ----------------------------------------------------------------------------
// SM3 hash engine checker
// Watches both channels, predicts the digest words of each finished message
// with a behavioural SM3 and compares every word, field by field.
// ----------------------------------------------------------------------------
module sm3_hash_checker import sm3_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  data_byte_i,
  input  logic        has_byte_i,
  input  logic        end_of_message_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] digest_word_i,
  input  logic [2:0]  word_index_i,
  input  logic        last_word_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          digests_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  logic [31:0]  chain_q [8];
  logic [7:0]   msg_block [64];
  int unsigned  fill_q;
  logic [63:0]  msg_bits;
  digest_word_t digest_words_q [$];
  int           fail_count;
  int           digests;

  assign fail_count_o = fail_count;
  assign pending_o    = digest_words_q.size();
  assign digests_o    = digests;

  function automatic logic [31:0] rol32(logic [31:0] x, int unsigned n);
    n = n % 32;
    if (n == 0) return x;
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [31:0] mix0(logic [31:0] x);
    return x ^ rol32(x, 9) ^ rol32(x, 17);
  endfunction

  function automatic logic [31:0] mix1(logic [31:0] x);
    return x ^ rol32(x, 15) ^ rol32(x, 23);
  endfunction

  task automatic compress_msg_block();
    logic [31:0] w [68];
    logic [31:0] a, b, c, d, e, f, g, h, tj, a12, ss1, ss2, ff, gg, tt1, tt2;
    for (int j = 0; j < 16; j++)
      w[j] = {msg_block[4*j], msg_block[4*j+1], msg_block[4*j+2], msg_block[4*j+3]};
    for (int j = 16; j < 68; j++)
      w[j] = mix1(w[j-16] ^ w[j-9] ^ rol32(w[j-3], 15)) ^ rol32(w[j-13], 7) ^ w[j-6];
    a = chain_q[0]; b = chain_q[1]; c = chain_q[2]; d = chain_q[3];
    e = chain_q[4]; f = chain_q[5]; g = chain_q[6]; h = chain_q[7];
    for (int j = 0; j < 64; j++) begin
      tj  = (j < 16) ? TJ_LO : TJ_HI;
      a12 = rol32(a, 12);
      ss1 = rol32(a12 + e + rol32(tj, j), 7);
      ss2 = ss1 ^ a12;
      if (j < 16) begin
        ff = a ^ b ^ c;
        gg = e ^ f ^ g;
      end else begin
        ff = (a & b) | (a & c) | (b & c);
        gg = (e & f) | (~e & g);
      end
      tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
      tt2 = gg + h + ss1 + w[j];
      d = c; c = rol32(b, 9); b = a; a = tt1;
      h = g; g = rol32(f, 19); f = e; e = mix0(tt2);
    end
    chain_q[0] ^= a; chain_q[1] ^= b; chain_q[2] ^= c; chain_q[3] ^= d;
    chain_q[4] ^= e; chain_q[5] ^= f; chain_q[6] ^= g; chain_q[7] ^= h;
  endtask

  task automatic restart_msg();
    chain_q = '{IV0, IV1, IV2, IV3, IV4, IV5, IV6, IV7};
    fill_q   = 0;
    msg_bits = '0;
  endtask

  task automatic absorb_request(logic [7:0] data, logic has, logic fin);
    logic [63:0] bits;
    if (has) begin
      msg_bits += 64'd8;
      msg_block[fill_q] = data;
      fill_q++;
      if (fill_q == 64) begin
        compress_msg_block();
        fill_q = 0;
      end
    end
    if (!fin) return;
    bits = msg_bits;
    msg_block[fill_q] = PAD_BYTE;
    fill_q++;
    // late padding: length goes into a second block
    if (fill_q > 56) begin
      while (fill_q < 64) msg_block[fill_q++] = 8'h00;
      compress_msg_block();
      fill_q = 0;
    end
    while (fill_q < 56) msg_block[fill_q++] = 8'h00;
    for (int i = 0; i < 8; i++) msg_block[56+i] = bits[63-8*i -: 8];
    compress_msg_block();
    for (int i = 0; i < 8; i++)
      digest_words_q.push_back('{chain_q[i], 3'(i), i == 7});
    restart_msg();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    digest_word_t exp_w;
    if (!rst_ni) begin
      restart_msg();
      digest_words_q.delete();
      fail_count = 0;
      digests    = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (digest_words_q.size() == 0) begin
          $display("%0t: unexpected digest word %h idx %0d", $time, digest_word_i,
                   word_index_i);
          fail_count++;
        end else begin
          exp_w = digest_words_q.pop_front();
          if (digest_word_i !== exp_w.word || word_index_i !== exp_w.index ||
              last_word_i !== exp_w.last) begin
            $display("%0t: digest word exp %h/%0d/%0b got %h/%0d/%0b", $time,
                     exp_w.word, exp_w.index, exp_w.last,
                     digest_word_i, word_index_i, last_word_i);
            fail_count++;
          end
          if (exp_w.last) digests++;
        end
      end
      if (in_valid_i && in_ready_i)
        absorb_request(data_byte_i, has_byte_i, end_of_message_i);
    end
  end
endmodule

// ----- tb/tb_sm3_hash_engine.sv -----
// ----------------------------------------------------------------------------
// SM3 hash engine testbench
// Feeds directed and random byte messages with random gaps and back-pressure;
// the checker predicts and compares every digest word.
// ----------------------------------------------------------------------------
module tb_sm3_hash_engine;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 300;
  localparam int REQ_TARGET = 430;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = '0;
  logic        has_byte_i = 1'b0;
  logic        end_of_message_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_word_o;
  int          fail_count, pending, digests;
  int          idle_cycles = 0;
  int          requests = 0;
  int          msg_len;
  bit          calm = 1'b0;

  always #1 clk_i = ~clk_i;

  sm3_hash_engine i_dut (.*);

  sm3_hash_checker i_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .data_byte_i,
    .has_byte_i, .end_of_message_i, .out_valid_i(out_valid_o), .out_ready_i,
    .digest_word_i(digest_word_o), .word_index_i(word_index_o),
    .last_word_i(last_word_o), .fail_count_o(fail_count), .pending_o(pending),
    .digests_o(digests)
  );

  // watchdog on handshake activity
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // random back-pressure, none while calm
  always @(negedge clk_i)
    if (rst_ni) out_ready_i <= calm || ($urandom_range(99) >= 24);

  // hold valid between back-to-back requests; drop it only on an idle cycle
  task automatic send_request(logic [7:0] data, logic has, logic fin);
    if (!calm) begin
      while ($urandom_range(99) < 24) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
      end
    end
    in_valid_i       <= 1'b1;
    data_byte_i      <= data;
    has_byte_i       <= has;
    end_of_message_i <= fin;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    requests++;
  endtask

  // message of n random bytes; finish carries a byte or is empty
  task automatic send_message(int n);
    bit with_byte;
    with_byte = (n > 0) && $urandom_range(1);
    for (int i = 0; i < n - with_byte; i++) begin
      send_request(8'($urandom), 1'b1, 1'b0);
      if ($urandom_range(19) == 0) send_request(8'($urandom), 1'b0, 1'b0);
    end
    send_request(8'($urandom), with_byte, 1'b1);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // directed: empty message, "abc", extremes, bare items, padding boundaries
    send_request(8'hff, 1'b0, 1'b1);
    send_request(8'h61, 1'b1, 1'b0);
    send_request(8'h62, 1'b1, 1'b0);
    send_request(8'h63, 1'b1, 1'b1);
    send_request(8'h00, 1'b0, 1'b0);
    send_request(8'hff, 1'b1, 1'b0);
    send_request(8'h00, 1'b1, 1'b0);
    send_request(8'hff, 1'b0, 1'b0);
    send_request(8'h55, 1'b0, 1'b1);
    send_message(55);
    send_message(56);
    send_message(63);
    send_message(64);
    // random messages, mostly short, with a calm stretch in the middle
    while (requests < REQ_TARGET) begin
      calm = (requests > 200 && requests < 280);
      msg_len = ($urandom_range(9) == 0) ? $urandom_range(130) : $urandom_range(70);
      if (msg_len > REQ_TARGET - requests) msg_len = REQ_TARGET - requests;
      send_message(msg_len);
    end
    in_valid_i <= 1'b0;
    calm = 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d requests; checked %0d digests including empty, padding-edge",
             requests, digests);
    $display("and multi-block messages under random gaps and stalls.");
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

// ----- files.f -----
design/sm3_pkg.sv
design/sm3_round.sv
design/sm3_hash_engine.sv
tb/sm3_hash_checker.sv
tb/tb_sm3_hash_engine.sv
